/* src/assert_macros.svh */
// Assertion helpers for the input change log block.
// Every check is sampled on i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ICL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("icl: same-cycle check failed");

// Next-cycle implication
`define ICL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("icl: next-cycle check failed");

`endif

/* src/icl_pkg.sv */
// ----------------------------------------------------------------------------
// icl_pkg
// Shared types and constants for the input change log record/replay block.
// ----------------------------------------------------------------------------
`default_nettype none

package icl_pkg;

    // default sizing
    localparam int LOG_DEPTH_DEF  = 1024;
    localparam int TICK_WIDTH_DEF = 32;

    // fixed field widths
    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int MODE_W  = 2;
    localparam int COUNT_W = 11;

    // operation codes; the three codes above stop_play are rejected
    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_START_REC  = 3'd1,
        OP_STOP_REC   = 3'd2,
        OP_START_PLAY = 3'd3,
        OP_STOP_PLAY  = 3'd4
    } t_op;

    // operating modes
    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE = 2'd0,
        MODE_REC  = 2'd1,
        MODE_PLAY = 2'd2
    } t_mode;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch request payload, launch log read
        logic execute;  // apply request to state, load result
    } t_dp_cmd;

endpackage

`default_nettype wire

/* src/icl_if.sv */
// ----------------------------------------------------------------------------
// icl_in_if / icl_out_if
// Valid/ready channels for requests into and results out of the change log.
// ----------------------------------------------------------------------------
`default_nettype none

interface icl_in_if;
    import icl_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] input_bits;

    modport source (output valid, output operation, output input_bits, input ready);
    modport sink   (input valid, input operation, input input_bits, output ready);
endinterface

interface icl_out_if;
    import icl_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  replay_input;
    logic [MODE_W-1:0]  mode;
    logic               play_ended;
    logic               log_full;
    logic               command_rejected;
    logic [COUNT_W-1:0] entry_count_out;

    modport source (output valid, output replay_input, output mode, output play_ended,
                    output log_full, output command_rejected, output entry_count_out,
                    input ready);
    modport sink   (input valid, input replay_input, input mode, input play_ended,
                    input log_full, input command_rejected, input entry_count_out,
                    output ready);
endinterface

`default_nettype wire

/* src/icl_ctrl.sv */
// ----------------------------------------------------------------------------
// icl_ctrl
// Request/result handshake controller; sequences capture and execute steps.
// ----------------------------------------------------------------------------
`default_nettype none

module icl_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output icl_pkg::t_dp_cmd     o_cmd
);
    import icl_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake outputs
    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = ST_RESP;
            end
            ST_RESP: begin
                // a new request may enter as the result leaves
                o_out_valid   = 1'b1;
                o_in_ready    = i_out_ready;
                o_cmd.capture = i_out_ready && i_in_valid;
                if (i_out_ready) begin
                    n_state = i_in_valid ? ST_EXEC : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/icl_dp.sv */
// ----------------------------------------------------------------------------
// icl_dp
// Datapath: mode and tick state, change log memory, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module icl_dp #(
    parameter int LOG_DEPTH  = icl_pkg::LOG_DEPTH_DEF,
    parameter int TICK_WIDTH = icl_pkg::TICK_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire icl_pkg::t_dp_cmd             i_cmd,
    input  wire logic [icl_pkg::OP_W-1:0]     i_operation,
    input  wire logic [icl_pkg::BYTE_W-1:0]   i_input_bits,
    output logic      [icl_pkg::BYTE_W-1:0]   o_replay_input,
    output logic      [icl_pkg::MODE_W-1:0]   o_mode,
    output logic                              o_play_ended,
    output logic                              o_log_full,
    output logic                              o_command_rejected,
    output logic      [icl_pkg::COUNT_W-1:0]  o_entry_count_out
);
    import icl_pkg::*;

    localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
    localparam int ADDR_W = $clog2(LOG_DEPTH);
    localparam int WORD_W = TICK_WIDTH + BYTE_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LOG_DEPTH);

    // captured request
    t_op               r_op;
    logic [BYTE_W-1:0] r_byte;

    // block state
    t_mode                r_mode,       n_mode;
    logic [TICK_WIDTH-1:0] r_elapsed,   n_elapsed;
    logic [CNT_W-1:0]     r_count,      n_count;
    logic [CNT_W-1:0]     r_play_index, n_play_index;
    logic [BYTE_W-1:0]    r_last,       n_last;
    logic [BYTE_W-1:0]    r_hold,       n_hold;

    // log memory, one word per entry: {tick, byte}
    logic [WORD_W-1:0] r_log_mem [LOG_DEPTH];
    logic [WORD_W-1:0] r_rd_data;
    logic [TICK_WIDTH-1:0] w_rd_tick;
    logic [BYTE_W-1:0]     w_rd_byte;
    logic                  w_wr_en;

    // result
    logic [BYTE_W-1:0] r_res_replay, n_res_replay;
    logic              r_res_ended,  n_res_ended;
    logic              r_res_full,   n_res_full;
    logic              r_res_rej,    n_res_rej;

    logic [CNT_W+COUNT_W-1:0] w_cnt_ext;

    assign w_rd_tick = r_rd_data[WORD_W-1:BYTE_W];
    assign w_rd_byte = r_rd_data[BYTE_W-1:0];

    // request capture and log read at the current playback position
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= t_op'(i_operation);
            r_byte    <= i_input_bits;
            r_rd_data <= r_log_mem[r_play_index[ADDR_W-1:0]];
        end
    end

    // log write: append at the current fill level
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_log_mem[r_count[ADDR_W-1:0]] <= {r_elapsed, r_byte};
        end
    end

    // request execution
    always_comb begin
        n_mode       = r_mode;
        n_elapsed    = r_elapsed;
        n_count      = r_count;
        n_play_index = r_play_index;
        n_last       = r_last;
        n_hold       = r_hold;
        n_res_replay = '0;
        n_res_ended  = 1'b0;
        n_res_full   = 1'b0;
        n_res_rej    = 1'b0;
        w_wr_en      = 1'b0;
        case (r_op)
            OP_TICK: begin
                case (r_mode)
                    MODE_REC: begin
                        if (r_byte != r_last) begin
                            if (r_count < DEPTH_C) begin
                                w_wr_en = i_cmd.execute;
                                n_count = r_count + 1'b1;
                                n_last  = r_byte;
                            end else begin
                                n_res_full = 1'b1;
                            end
                        end
                        n_elapsed = r_elapsed + 1'b1;
                    end
                    MODE_PLAY: begin
                        if (r_play_index >= r_count) begin
                            // log exhausted
                            n_mode      = MODE_IDLE;
                            n_res_ended = 1'b1;
                        end else begin
                            if (r_elapsed == w_rd_tick) begin
                                n_res_replay = w_rd_byte;
                                n_hold       = w_rd_byte;
                                n_play_index = r_play_index + 1'b1;
                            end else begin
                                n_res_replay = r_hold;
                            end
                            n_elapsed = r_elapsed + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_START_REC: begin
                if (r_mode == MODE_IDLE) begin
                    n_count   = '0;
                    n_last    = '0;
                    n_elapsed = '0;
                    n_mode    = MODE_REC;
                end else begin
                    n_res_rej = 1'b1;
                end
            end
            OP_STOP_REC: begin
                if (r_mode == MODE_REC) begin
                    n_mode = MODE_IDLE;
                end else begin
                    n_res_rej = 1'b1;
                end
            end
            OP_START_PLAY: begin
                if (r_mode == MODE_IDLE) begin
                    n_play_index = '0;
                    n_elapsed    = '0;
                    n_hold       = '0;
                    n_mode       = MODE_PLAY;
                end else begin
                    n_res_rej = 1'b1;
                end
            end
            OP_STOP_PLAY: begin
                if (r_mode == MODE_PLAY) begin
                    n_mode = MODE_IDLE;
                end else begin
                    n_res_rej = 1'b1;
                end
            end
            default: begin
                n_res_rej = 1'b1;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_elapsed    <= '0;
            r_count      <= '0;
            r_play_index <= '0;
            r_last       <= '0;
            r_hold       <= '0;
        end else if (i_cmd.execute) begin
            r_mode       <= n_mode;
            r_elapsed    <= n_elapsed;
            r_count      <= n_count;
            r_play_index <= n_play_index;
            r_last       <= n_last;
            r_hold       <= n_hold;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_res_replay <= n_res_replay;
            r_res_ended  <= n_res_ended;
            r_res_full   <= n_res_full;
            r_res_rej    <= n_res_rej;
        end
    end

    // mode and count stay put until the next request executes
    assign w_cnt_ext          = {{COUNT_W{1'b0}}, r_count};
    assign o_replay_input     = r_res_replay;
    assign o_mode             = r_mode;
    assign o_play_ended       = r_res_ended;
    assign o_log_full         = r_res_full;
    assign o_command_rejected = r_res_rej;
    assign o_entry_count_out  = w_cnt_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

/* src/input_change_log_record_replay.sv */
// A request is captured when accepted, executed in the EXEC state, and its result
// is presented in the RESP state; no new request is accepted until that result is
// taken, and the capture/log-read step and the execute step run for each request.
// A new request is accepted in the same cycle the previous result is taken.
// Reset: synchronous active low; mode idle, log empty, counters zero. The
//   log memory is not cleared and holds data only once written.
// ----------------------------------------------------------------------------
// input_change_log_record_replay
// Records changes of an 8-bit control input with their tick and replays them.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module input_change_log_record_replay #(
    parameter int LOG_DEPTH  = icl_pkg::LOG_DEPTH_DEF,
    parameter int TICK_WIDTH = icl_pkg::TICK_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    icl_in_if.sink     i_in,
    icl_out_if.source  o_out
);
    import icl_pkg::*;

    t_dp_cmd w_cmd;

    // handshake controller
    icl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    // datapath and log memory
    icl_dp #(
        .LOG_DEPTH  (LOG_DEPTH),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_operation        (i_in.operation),
        .i_input_bits       (i_in.input_bits),
        .o_replay_input     (o_out.replay_input),
        .o_mode             (o_out.mode),
        .o_play_ended       (o_out.play_ended),
        .o_log_full         (o_out.log_full),
        .o_command_rejected (o_out.command_rejected),
        .o_entry_count_out  (o_out.entry_count_out)
    );

    // checks
    `ICL_ASSERT_NXT(a_accept_no_result, i_in.valid && i_in.ready, !o_out.valid)
    `ICL_ASSERT_NXT(a_exec_gives_result, w_cmd.execute, o_out.valid)
    `ICL_ASSERT_IMP(a_end_is_idle, o_out.valid && o_out.play_ended, o_out.mode == MODE_IDLE)
    `ICL_ASSERT_IMP(a_full_in_rec, o_out.valid && o_out.log_full, o_out.mode == MODE_REC)

endmodule

`default_nettype wire
